>>> sv/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg: shared types and constants of the bounded byte stack
// Holds the stack geometry, the operation codes, the command and result
// words and the memory port bundles.
// ----------------------------------------------------------------------------
package bbs_pkg;

    // Stack geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 7;
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 3'd0,
        OP_POP       = 3'd1,
        OP_PEEK      = 3'd2,
        OP_DUMP_DOWN = 3'd3,
        OP_DUMP_UP   = 3'd4
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] push_byte;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_last;
    } t_res;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

endpackage

>>> sv/bbs_mem.sv
// ----------------------------------------------------------------------------
// bbs_mem: entry storage of the byte stack
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bbs_mem
    import bbs_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_wr           i_wr,
    input  t_mem_rd           i_rd,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/bounded_byte_stack.sv
// ----------------------------------------------------------------------------
// bounded_byte_stack: last-in first-out byte stack with settable capacity
// Push, pop, peek and two dump orders over a single-port-read byte memory.
// ----------------------------------------------------------------------------
//
//  channel   | signals                         | handshake
//  ----------+---------------------------------+---------------------------------
//  command   | start, busy, i_cmd              | taken when start & !busy
//  result    | o_strobe, o_result              | each word strobed, no stall
//  capacity  | i_cfg_we, i_cfg_data            | written when i_cfg_we is high
//
//  Push, pop and peek leave busy low, and a new command may follow
//  in the very next cycle. Peek shows its word in the cycle after the accept.
//  A dump of n entries issues one memory read per entry: busy is high
//  after the accept while the reads after the first are issued, words
//  appear from the cycle after the accept, one per cycle, the final one flagged by is_last.
//  Reset (synchronous, active low) empties the stack and sets capacity to 64;
//  the entry memory itself is not cleared, only the fill count.
//  The receiver cannot hold words off, so nothing here ever stalls on it.
//
module bounded_byte_stack
    import bbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    output logic             o_strobe,
    output t_res             o_result,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data
);

    // Control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_remain, n_remain;   // dump reads still to issue
    logic [ADDR_W-1:0] r_addr, n_addr;       // next dump read address
    logic              r_up, n_up;           // dump direction: base to top
    logic [CAP_W-1:0]  r_cap;
    logic              r_out_valid;
    logic              r_out_last;

    // Memory ports
    t_mem_wr           mem_wr;
    t_mem_rd           mem_rd;
    logic              rd_last;
    logic [BYTE_W-1:0] rd_data;

    logic              accept;
    logic              is_dump;
    logic [CNT_W-1:0]  usable;
    logic [CNT_W-1:0]  fill_m1;
    logic [CNT_W-1:0]  fill_m2;

    assign accept  = start && !busy;
    assign is_dump = (i_cmd.op == OP_DUMP_DOWN) || (i_cmd.op == OP_DUMP_UP);
    // Clamp capacity to the physical depth
    assign usable  = (r_cap > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cap[CNT_W-1:0];
    assign fill_m1 = r_fill - CNT_W'(1);
    assign fill_m2 = r_fill - CNT_W'(2);

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // A dump of more than one entry needs further read cycles
                if (accept && is_dump && (r_fill > CNT_W'(1))) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (r_remain == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control and memory access
    always_comb begin
        n_fill   = r_fill;
        n_remain = r_remain;
        n_addr   = r_addr;
        n_up     = r_up;
        mem_wr   = '0;
        mem_rd   = '0;
        rd_last  = 1'b0;
        busy     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.op)
                        OP_PUSH: begin
                            // Drop the byte when full
                            if (r_fill < usable) begin
                                mem_wr.en   = 1'b1;
                                mem_wr.addr = r_fill[ADDR_W-1:0];
                                mem_wr.data = i_cmd.push_byte;
                                n_fill      = r_fill + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_fill != '0) begin
                                n_fill = fill_m1;
                            end
                        end
                        OP_PEEK: begin
                            if (r_fill != '0) begin
                                mem_rd.en   = 1'b1;
                                mem_rd.addr = fill_m1[ADDR_W-1:0];
                                rd_last     = 1'b1;
                            end
                        end
                        OP_DUMP_DOWN: begin
                            // Issue the top entry now, walk down from there
                            if (r_fill != '0) begin
                                mem_rd.en   = 1'b1;
                                mem_rd.addr = fill_m1[ADDR_W-1:0];
                                rd_last     = (r_fill == CNT_W'(1));
                                n_remain    = fill_m1;
                                n_addr      = fill_m2[ADDR_W-1:0];
                                n_up        = 1'b0;
                            end
                        end
                        OP_DUMP_UP: begin
                            // Issue the base entry now, walk up from there
                            if (r_fill != '0) begin
                                mem_rd.en   = 1'b1;
                                mem_rd.addr = '0;
                                rd_last     = (r_fill == CNT_W'(1));
                                n_remain    = fill_m1;
                                n_addr      = ADDR_W'(1);
                                n_up        = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DUMP: begin
                busy        = 1'b1;
                mem_rd.en   = 1'b1;
                mem_rd.addr = r_addr;
                rd_last     = (r_remain == CNT_W'(1));
                n_remain    = r_remain - CNT_W'(1);
                n_addr      = r_up ? (r_addr + ADDR_W'(1)) : (r_addr - ADDR_W'(1));
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_remain    <= '0;
            r_addr      <= '0;
            r_up        <= 1'b0;
            r_cap       <= CAP_W'(64);
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_remain    <= n_remain;
            r_addr      <= n_addr;
            r_up        <= n_up;
            // Every read turns into exactly one result word next cycle
            r_out_valid <= mem_rd.en;
            r_out_last  <= rd_last;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    bbs_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd      (mem_rd),
        .o_rd_data (rd_data)
    );

    assign o_strobe = r_out_valid;
    assign o_result = t_res'{out_byte: rd_data, is_last: r_out_last};

endmodule

>>> sv/bbs_chk.sv
// ----------------------------------------------------------------------------
// bbs_chk: port-level checks of the bounded byte stack
// Watches the command, result and busy ports over time.
// ----------------------------------------------------------------------------
module bbs_chk
    import bbs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input t_cmd             i_cmd,
    input logic             o_strobe,
    input t_res             o_result
);

    // A word only follows a taken command or a dump cycle
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy || start))
        else $error("result word without a command or dump cycle");

    // Busy only rises after a dump was taken
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && ((i_cmd.op == OP_DUMP_DOWN)
                                        || (i_cmd.op == OP_DUMP_UP))))
        else $error("busy rose without a dump");

    // Every busy cycle delivers a word in the next cycle
    a_busy_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe)
        else $error("dump cycle without a word");

    // The end of a dump shows the flagged final word
    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_result.is_last))
        else $error("dump ended without its final word");

    // A peek word is always flagged last
    a_peek_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(start && !busy && (i_cmd.op == OP_PEEK)) && o_strobe)
            |-> o_result.is_last)
        else $error("peek word not flagged last");

endmodule

bind bounded_byte_stack bbs_chk u_bbs_chk (.*);
